// File: design/vtb_pkg.sv
package vtb_pkg;

  // field widths
  localparam int COORD_W   = 16;
  localparam int SAMPLE_W  = 8;
  localparam int SIZE_W    = 7;
  localparam int PLANE_W   = 6;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // widths of the address arithmetic, bounded by the size register widths
  localparam int WH_W  = 2 * SIZE_W;
  localparam int WHD_W = WH_W + PLANE_W;
  localparam int SUM_W = WHD_W + 1;

  // request kinds
  localparam logic [1:0] KIND_BLEND = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ORG_Z  = 3'd5;

  typedef struct packed {
    logic [1:0]          kind;
    logic [COORD_W-1:0]  voxel_x;
    logic [COORD_W-1:0]  voxel_y;
    logic [COORD_W-1:0]  voxel_z;
    logic                channel;
    logic [SAMPLE_W-1:0] sample;
  } vtb_req_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] stored_value;
    logic                in_region;
  } vtb_res_t;

endpackage

// File: design/voxel_tile_blend_into_volume.sv
// channel   direction  handshake                  payload
// request   in         start, accepted if !busy   vtb_req_t request
// result    out        done strobe, one cycle     vtb_res_t result
// config    in         cfg_we, no wait            cfg_index, cfg_data
//
// One request per cycle while busy is low, through stages 1-3 and a result register.
// The voxel store is one memory with a registered read; a read-modify-write
// spans two stages, and a write is forwarded to a read of the same voxel.
// After reset a clearing pass zeroes the store, one voxel per cycle, over all
// MAX_WIDTH*MAX_HEIGHT*MAX_DEPTH*MAX_CHANNELS voxels (262144 by default).
// busy also stays high after a register write, while cfg_hold counts down.
// Results cannot be held off by the receiver.
module voxel_tile_blend_into_volume #(
  parameter int MAX_WIDTH    = 64,
  parameter int MAX_HEIGHT   = 64,
  parameter int MAX_DEPTH    = 32,
  parameter int MAX_CHANNELS = 2
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  vtb_pkg::vtb_req_t             request,
  output logic                          done,
  output vtb_pkg::vtb_res_t             result,
  input  logic                          cfg_we,
  input  logic [vtb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vtb_pkg::CFG_DATA_W-1:0] cfg_data
);
  import vtb_pkg::*;

  localparam longint unsigned DEPTH =
    longint'(MAX_WIDTH) * MAX_HEIGHT * MAX_DEPTH * MAX_CHANNELS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // configuration registers
  logic [SIZE_W-1:0]  region_width;
  logic [SIZE_W-1:0]  region_height;
  logic [PLANE_W-1:0] region_depth;
  logic [COORD_W-1:0] origin_x;
  logic [COORD_W-1:0] origin_y;
  logic [COORD_W-1:0] origin_z;
  logic [1:0]         cfg_hold;

  // clearing pass
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;

  // derived sizes
  logic [SIZE_W-1:0]  w_eff;
  logic [SIZE_W-1:0]  h_eff;
  logic [PLANE_W-1:0] d_eff;
  logic [WH_W-1:0]    wh;
  logic [WHD_W-1:0]   whd;

  // stage 1
  logic     s1_valid;
  vtb_req_t s1_req;
  logic [COORD_W-1:0] dx_full;
  logic [COORD_W-1:0] dy_full;
  logic [COORD_W-1:0] dz_full;
  logic               s1_in;

  // stage 2
  logic                s2_valid;
  logic [1:0]          s2_kind;
  logic [SAMPLE_W-1:0] s2_sample;
  logic                s2_in;
  logic                s2_ch;
  logic [SIZE_W-1:0]   s2_dx;
  logic [WHD_W-1:0]    s2_dzwh;
  logic [WH_W-1:0]     s2_dyw;
  logic [SUM_W-1:0]    s2_sum;
  logic [ADDR_W-1:0]   s2_addr;

  // stage 3
  logic                s3_valid;
  logic [1:0]          s3_kind;
  logic [SAMPLE_W-1:0] s3_sample;
  logic                s3_in;
  logic [ADDR_W-1:0]   s3_addr;
  logic [SAMPLE_W-1:0] old_val;
  logic [SAMPLE_W:0]   blend_sum;
  logic [SAMPLE_W-1:0] new_val;
  logic                s3_wr;

  // store port
  logic                mem_wr_en;
  logic [ADDR_W-1:0]   mem_wr_addr;
  logic [SAMPLE_W-1:0] mem_wr_data;

  logic accept;

  assign busy   = clearing || (cfg_hold != 2'd0);
  assign accept = start && !busy;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      region_width  <= SIZE_W'(64);
      region_height <= SIZE_W'(64);
      region_depth  <= PLANE_W'(32);
      origin_x      <= '0;
      origin_y      <= '0;
      origin_z      <= '0;
      cfg_hold      <= 2'd0;
    end else begin
      if (cfg_we) begin
        cfg_hold <= 2'd2;
        case (cfg_index)
          REG_WIDTH:  region_width  <= cfg_data[SIZE_W-1:0];
          REG_HEIGHT: region_height <= cfg_data[SIZE_W-1:0];
          REG_DEPTH:  region_depth  <= cfg_data[PLANE_W-1:0];
          REG_ORG_X:  origin_x      <= cfg_data;
          REG_ORG_Y:  origin_y      <= cfg_data;
          REG_ORG_Z:  origin_z      <= cfg_data;
          default: ;
        endcase
      end else if (cfg_hold != 2'd0) begin
        cfg_hold <= cfg_hold - 2'd1;
      end
    end
  end

  // sizes above their maximum count as the maximum
  assign w_eff = (32'(region_width) > MAX_WIDTH) ? SIZE_W'(MAX_WIDTH) : region_width;
  assign h_eff = (32'(region_height) > MAX_HEIGHT) ? SIZE_W'(MAX_HEIGHT) : region_height;
  assign d_eff = (32'(region_depth) > MAX_DEPTH) ? PLANE_W'(MAX_DEPTH) : region_depth;

  // plane and channel strides, wh and then whd registered from the sizes
  always_ff @(posedge clk) begin
    wh  <= WH_W'(w_eff) * WH_W'(h_eff);
    whd <= WHD_W'(wh) * WHD_W'(d_eff);
  end

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) begin
        clearing <= 1'b0;
      end
    end
  end

  // stage 1: capture the request
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    s1_req <= request;
  end

  // region check and partial offsets
  assign dx_full = s1_req.voxel_x - origin_x;
  assign dy_full = s1_req.voxel_y - origin_y;
  assign dz_full = s1_req.voxel_z - origin_z;
  assign s1_in = (s1_req.voxel_x >= origin_x) && (dx_full < COORD_W'(w_eff))
              && (s1_req.voxel_y >= origin_y) && (dy_full < COORD_W'(h_eff))
              && (s1_req.voxel_z >= origin_z) && (dz_full < COORD_W'(d_eff))
              && (32'(s1_req.channel) < MAX_CHANNELS);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    s2_kind   <= s1_req.kind;
    s2_sample <= s1_req.sample;
    s2_in     <= s1_in;
    s2_ch     <= s1_req.channel;
    s2_dx     <= dx_full[SIZE_W-1:0];
    s2_dzwh   <= WHD_W'(dz_full[PLANE_W-1:0]) * WHD_W'(wh);
    s2_dyw    <= WH_W'(dy_full[SIZE_W-1:0]) * WH_W'(w_eff);
  end

  // stage 2: linear address, memory read issued
  assign s2_sum = (s2_ch ? SUM_W'(whd) : '0) + SUM_W'(s2_dzwh)
                + SUM_W'(s2_dyw) + SUM_W'(s2_dx);
  assign s2_addr = ADDR_W'(s2_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else begin
      s3_valid <= s2_valid;
    end
    s3_kind   <= s2_kind;
    s3_sample <= s2_sample;
    s3_in     <= s2_in;
    s3_addr   <= s2_addr;
  end

  // stage 3: modify and write back
  assign blend_sum = {1'b0, old_val} + {1'b0, s3_sample};
  always_comb begin
    case (s3_kind)
      KIND_BLEND: new_val = (old_val != '0) ? blend_sum[SAMPLE_W:1] : s3_sample;
      KIND_CLEAR: new_val = '0;
      default:    new_val = old_val;
    endcase
  end
  assign s3_wr = s3_valid && s3_in && ((s3_kind == KIND_BLEND) || (s3_kind == KIND_CLEAR));

  assign mem_wr_en   = clearing || s3_wr;
  assign mem_wr_addr = clearing ? clr_addr : s3_addr;
  assign mem_wr_data = clearing ? '0 : new_val;

  vtb_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (s2_addr),
    .rd_data (old_val),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s3_valid;
    end
    result.stored_value <= s3_in ? new_val : '0;
    result.in_region    <= s3_in;
  end

endmodule

// File: design/vtb_store.sv
module vtb_store #(
  parameter longint unsigned DEPTH  = 262144,
  parameter int              ADDR_W = 18
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ADDR_W-1:0]            rd_addr,
  output logic [vtb_pkg::SAMPLE_W-1:0] rd_data,
  input  logic                         wr_en,
  input  logic [ADDR_W-1:0]            wr_addr,
  input  logic [vtb_pkg::SAMPLE_W-1:0] wr_data
);
  import vtb_pkg::*;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] ram_q;
  logic                fwd_hit;
  logic [SAMPLE_W-1:0] fwd_data;

  // single port write, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    ram_q    <= mem[rd_addr];
    fwd_data <= wr_data;
  end

  // a write to the address read at the same edge wins over the array
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else begin
      fwd_hit <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_hit ? fwd_data : ram_q;

endmodule

// File: design/vtb_checker.sv
module vtb_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              cfg_we,
  input logic              done,
  input vtb_pkg::vtb_res_t result
);
  import vtb_pkg::*;

  // every accepted request is followed by its result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("request without result");

  // a result only follows an accepted request
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 4))
    else $error("result without request");

  // out-of-region results carry zero
  a_out_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.in_region) |-> (result.stored_value == '0))
    else $error("nonzero value outside region");

  // the clearing pass holds requests off right after reset
  a_clear_busy: assert property (@(posedge clk)
    rst |=> busy)
    else $error("not busy after reset");

  // register writes hold requests off while strides settle
  a_cfg_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> busy)
    else $error("request window open right after register write");

endmodule

bind voxel_tile_blend_into_volume vtb_checker u_vtb_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cfg_we (cfg_we),
  .done   (done),
  .result (result)
);
